/* hw/rtl/minimal_standard_lcg_range_top_defines.svh */
// assertion macros for the minimal standard lcg range block
`ifndef MINIMAL_STANDARD_LCG_RANGE_TOP_DEFINES_SVH
`define MINIMAL_STANDARD_LCG_RANGE_TOP_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define MSLCG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define MSLCG_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/mslcg_pkg.sv */
// types and constants of the minimal standard lcg range block
package mslcg_pkg;

    localparam int unsigned SEED_W = 31;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned SPAN_W = 33;
    localparam int unsigned MB_W   = 16;
    localparam int unsigned PROD_W = SPAN_W + MB_W;
    localparam int unsigned ACC_W  = 63;

    localparam logic [MB_W-1:0]   LCG_MUL    = 16'd16807;
    localparam logic [DATA_W-1:0] LCG_MOD    = 32'h7FFF_FFFF;
    localparam logic [SEED_W-1:0] SEED_RESET = 31'd123456789;
    localparam logic [SEED_W-1:0] SEED_ONES  = 31'h7FFF_FFFF;

    // operation codes
    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // register select, taken from paddr[2]
    localparam logic REG_RANGE_LOW  = 1'b0;
    localparam logic REG_RANGE_HIGH = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_SEED,
        S_REDUCE,
        S_MUL_LO,
        S_MUL_HI,
        S_ACCUM,
        S_FINISH
    } t_state;

endpackage

/* hw/rtl/minimal_standard_lcg_range_top.sv */
// minimal standard lcg with integer range output, top level
//
// Park-Miller minimal standard generator: a draw advances the seed to
// 16807 * seed mod (2^31 - 1) and returns the new seed together with
// lo + ((seed * (hi - lo + 1)) >> 31), where lo and hi are the two range
// registers put in order. A load replaces the seed; a load of zero or of
// 2^31 - 1 is rejected with o_seed_error set and the seed kept. A load
// result carries o_ranged_value = 0. The seed resets to 123456789.
// Timing: a load's result is written into the output register at the
// edge that takes the load. A draw walks a small sequencer over one
// shared 33 x 16 unsigned multiplier (seed product, modular fold, low
// and high partial products of the scaling, accumulate, final add), so
// the block holds o_in_stall high from a draw transfer until it is back
// in idle. New input is taken only when the output register is empty
// or being drained in the same cycle. Range registers sit at byte
// address 0 (range_low) and 4 (range_high); the user must write them
// only while idle, as the block itself does not enforce this.
module minimal_standard_lcg_range_top (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [30:0] i_seed_in,

    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_ranged_value,
    output logic [30:0] o_raw_seed,
    output logic        o_seed_error,

    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "minimal_standard_lcg_range_top_defines.svh"

    // state
    mslcg_pkg::t_state                   r_state, n_state;
    logic [mslcg_pkg::SEED_W-1:0]        r_seed;
    logic [mslcg_pkg::DATA_W-1:0]        r_range_low, r_range_high;
    logic [mslcg_pkg::DATA_W-1:0]        r_lo;
    logic [mslcg_pkg::SPAN_W-1:0]        r_span;
    logic [mslcg_pkg::PROD_W-1:0]        r_prod, r_phi;
    logic [mslcg_pkg::ACC_W-1:0]         r_acc;

    // output register
    logic                                r_out_valid;
    logic [mslcg_pkg::DATA_W-1:0]        r_out_ranged;
    logic [mslcg_pkg::SEED_W-1:0]        r_out_seed;
    logic                                r_out_err;

    // handshake
    logic w_in_xfer;
    logic w_out_free;
    logic w_cfg_wr;

    // shared multiplier
    logic [mslcg_pkg::SPAN_W-1:0] w_mul_a;
    logic [mslcg_pkg::MB_W-1:0]   w_mul_b;
    logic [mslcg_pkg::PROD_W-1:0] w_mul_p;

    // bounds ordering
    logic                         w_swap;
    logic [mslcg_pkg::DATA_W-1:0] w_lo, w_hi;
    logic [mslcg_pkg::SPAN_W-1:0] w_span;

    // modular fold and load check
    logic [mslcg_pkg::DATA_W-1:0] w_fold;
    logic [mslcg_pkg::DATA_W-1:0] w_fold_red;
    logic                         w_load_bad;
    logic [mslcg_pkg::ACC_W-1:0]  w_acc_sum;

    assign pready      = 1'b1;
    assign w_cfg_wr    = psel && penable && pwrite;
    assign prdata      = (paddr[2] == mslcg_pkg::REG_RANGE_HIGH) ? r_range_high : r_range_low;

    // output register is free now or drained this cycle
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_in_xfer   = i_in_valid && !o_in_stall;

    assign o_out_valid    = r_out_valid;
    assign o_ranged_value = r_out_ranged;
    assign o_raw_seed     = r_out_seed;
    assign o_seed_error   = r_out_err;

    // order the bounds and form the span, up to 2^32
    assign w_swap = $signed(r_range_high) < $signed(r_range_low);
    assign w_lo   = w_swap ? r_range_high : r_range_low;
    assign w_hi   = w_swap ? r_range_low  : r_range_high;
    assign w_span = {w_hi[mslcg_pkg::DATA_W-1], w_hi} - {w_lo[mslcg_pkg::DATA_W-1], w_lo}
                    + {{(mslcg_pkg::SPAN_W-1){1'b0}}, 1'b1};

    // 2^31 = 1 mod (2^31 - 1): add the high part onto the low part
    assign w_fold = {1'b0, r_prod[mslcg_pkg::SEED_W-1:0]}
                    + {{(mslcg_pkg::DATA_W - (mslcg_pkg::PROD_W - mslcg_pkg::SEED_W)){1'b0}},
                       r_prod[mslcg_pkg::PROD_W-1:mslcg_pkg::SEED_W]};
    assign w_fold_red = (w_fold >= mslcg_pkg::LCG_MOD) ? (w_fold - mslcg_pkg::LCG_MOD) : w_fold;

    assign w_load_bad = (i_seed_in == '0) || (i_seed_in == mslcg_pkg::SEED_ONES);

    // high partial product weighs 2^16; the full product stays below 2^63
    assign w_acc_sum = {{(mslcg_pkg::ACC_W - mslcg_pkg::PROD_W){1'b0}}, r_prod}
                       + {r_phi[mslcg_pkg::ACC_W-mslcg_pkg::MB_W-1:0], {mslcg_pkg::MB_W{1'b0}}};

    // operand selection for the one multiplier
    always_comb begin
        w_mul_a = {2'b00, r_seed};
        w_mul_b = mslcg_pkg::LCG_MUL;
        unique case (r_state)
            mslcg_pkg::S_MUL_LO: begin
                w_mul_a = r_span;
                w_mul_b = r_seed[mslcg_pkg::MB_W-1:0];
            end
            mslcg_pkg::S_MUL_HI: begin
                w_mul_a = r_span;
                w_mul_b = {1'b0, r_seed[mslcg_pkg::SEED_W-1:mslcg_pkg::MB_W]};
            end
            default: begin
                w_mul_a = {2'b00, r_seed};
                w_mul_b = mslcg_pkg::LCG_MUL;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mslcg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and stall
    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        unique case (r_state)
            mslcg_pkg::S_IDLE: begin
                o_in_stall = !w_out_free;
                if (i_in_valid && w_out_free && i_operation == mslcg_pkg::OP_DRAW) begin
                    n_state = mslcg_pkg::S_MUL_SEED;
                end
            end
            mslcg_pkg::S_MUL_SEED: n_state = mslcg_pkg::S_REDUCE;
            mslcg_pkg::S_REDUCE:   n_state = mslcg_pkg::S_MUL_LO;
            mslcg_pkg::S_MUL_LO:   n_state = mslcg_pkg::S_MUL_HI;
            mslcg_pkg::S_MUL_HI:   n_state = mslcg_pkg::S_ACCUM;
            mslcg_pkg::S_ACCUM:    n_state = mslcg_pkg::S_FINISH;
            mslcg_pkg::S_FINISH:   n_state = mslcg_pkg::S_IDLE;
            default:               n_state = mslcg_pkg::S_IDLE;
        endcase
    end

    // range registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= '0;
            r_range_high <= 32'd2;
        end else if (w_cfg_wr) begin
            if (paddr[2] == mslcg_pkg::REG_RANGE_LOW) begin
                r_range_low <= pwdata;
            end else begin
                r_range_high <= pwdata;
            end
        end
    end

    // seed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= mslcg_pkg::SEED_RESET;
        end else if (w_in_xfer && i_operation == mslcg_pkg::OP_LOAD && !w_load_bad) begin
            r_seed <= i_seed_in;
        end else if (r_state == mslcg_pkg::S_REDUCE) begin
            r_seed <= w_fold_red[mslcg_pkg::SEED_W-1:0];
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            mslcg_pkg::S_MUL_SEED: begin
                r_prod <= w_mul_p;
                r_lo   <= w_lo;
                r_span <= w_span;
            end
            mslcg_pkg::S_MUL_LO: r_prod <= w_mul_p;
            mslcg_pkg::S_MUL_HI: r_phi  <= w_mul_p;
            mslcg_pkg::S_ACCUM:  r_acc  <= w_acc_sum;
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == mslcg_pkg::S_FINISH) begin
            r_out_valid <= 1'b1;
        end else if (w_in_xfer && i_operation == mslcg_pkg::OP_LOAD) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == mslcg_pkg::S_FINISH) begin
            // scaled value is below the span, so the sum stays within [lo, hi]
            r_out_ranged <= r_lo + r_acc[mslcg_pkg::ACC_W-1:mslcg_pkg::SEED_W];
            r_out_seed   <= r_seed;
            r_out_err    <= 1'b0;
        end else if (w_in_xfer && i_operation == mslcg_pkg::OP_LOAD) begin
            r_out_ranged <= '0;
            r_out_seed   <= w_load_bad ? r_seed : i_seed_in;
            r_out_err    <= w_load_bad;
        end
    end

    // checks
    `MSLCG_ASSERT_IMP(a_seed_legal, 1'b1,
        (r_seed != '0) && (r_seed != mslcg_pkg::SEED_ONES), "seed left the legal range")
    `MSLCG_ASSERT_NXT(a_draw_starts, w_in_xfer && (i_operation == mslcg_pkg::OP_DRAW),
        r_state == mslcg_pkg::S_MUL_SEED, "draw transfer did not start the sequencer")
    `MSLCG_ASSERT_IMP(a_busy_out_empty, r_state != mslcg_pkg::S_IDLE,
        !r_out_valid, "output register occupied during a draw")

endmodule

/* sim/minimal_standard_lcg_range_top_tb.sv */
// testbench for the minimal standard lcg range block: seed and range prediction with checks
`timescale 1ns / 100ps

module minimal_standard_lcg_range_top_tb;

    localparam int          HALF_PERIOD      = 5;
    localparam int          RESET_CYCLES     = 6;
    localparam int          IDLE_PERCENT     = 12;
    localparam int          NUM_PHASES       = 10;
    localparam int          ITEMS_PER_PHASE  = 138;
    localparam int          HOLD_CYCLES      = 300;
    localparam int          TAIL_CYCLES      = 20;
    localparam longint      SCHRAGE_Q        = 127773;
    localparam longint      SCHRAGE_R        = 2836;
    localparam logic [31:0] RANGE_MIN        = 32'h8000_0000;
    localparam logic [31:0] RANGE_MAX        = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [31:0] ranged;
        logic [30:0] seed;
        logic        err;
    } t_draw_result;

    // holds the generator state, predicts each result and checks it on arrival
    class lcg_ledger;
        logic [30:0]  seed_now;
        logic [31:0]  bound_low;
        logic [31:0]  bound_high;
        t_draw_result owed[$];
        int unsigned  faults;

        function new();
            seed_now   = mslcg_pkg::SEED_RESET;
            bound_low  = 32'd0;
            bound_high = 32'd2;
            faults     = 0;
        endfunction

        function void set_bound(logic idx, logic [31:0] v);
            if (idx == mslcg_pkg::REG_RANGE_LOW) begin
                bound_low = v;
            end else begin
                bound_high = v;
            end
        endfunction

        // 16807 * s mod (2^31 - 1) by schrage's split
        function logic [30:0] park_miller_step(logic [30:0] s);
            longint cur;
            longint k;
            longint n;
            cur = longint'(s);
            k   = cur / SCHRAGE_Q;
            n   = longint'(mslcg_pkg::LCG_MUL) * (cur - k * SCHRAGE_Q) - k * SCHRAGE_R;
            if (n < 0) begin
                n = n + longint'(mslcg_pkg::LCG_MOD);
            end
            return n[30:0];
        endfunction

        function logic [31:0] fit_to_range(logic [30:0] s);
            longint          lo;
            longint          hi;
            longint          t;
            longint          val;
            longint unsigned span;
            longint unsigned prod;
            lo = $signed(bound_low);
            hi = $signed(bound_high);
            if (hi < lo) begin
                t  = lo;
                lo = hi;
                hi = t;
            end
            span = hi - lo + 1;
            prod = longint'(s) * span;
            val  = lo + longint'(prod >> 31);
            if (val < lo) begin
                val = lo;
            end
            if (val > hi) begin
                val = hi;
            end
            return val[31:0];
        endfunction

        function void note_request(logic op, logic [30:0] sd);
            t_draw_result r;
            r.ranged = 32'd0;
            r.err    = 1'b0;
            if (op == mslcg_pkg::OP_LOAD) begin
                // zero and all ones are both zero mod 2^31 - 1
                if (sd == 31'd0 || sd == mslcg_pkg::SEED_ONES) begin
                    r.err = 1'b1;
                end else begin
                    seed_now = sd;
                end
            end else begin
                seed_now = park_miller_step(seed_now);
                r.ranged = fit_to_range(seed_now);
            end
            r.seed = seed_now;
            owed.push_back(r);
        endfunction

        function void check_result(logic [31:0] ranged, logic [30:0] seed, logic err);
            t_draw_result e;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result ranged_value %0d raw_seed %0d seed_error %0b",
                         $time, $signed(ranged), seed, err);
                faults++;
                return;
            end
            e = owed.pop_front();
            if (ranged !== e.ranged) begin
                $display("%0t: ranged_value expected %0d got %0d",
                         $time, $signed(e.ranged), $signed(ranged));
                faults++;
            end
            if (seed !== e.seed) begin
                $display("%0t: raw_seed expected %0d got %0d", $time, e.seed, seed);
                faults++;
            end
            if (err !== e.err) begin
                $display("%0t: seed_error expected %0b got %0b", $time, e.err, err);
                faults++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_operation;
    logic [30:0] i_seed_in;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_ranged_value;
    logic [30:0] o_raw_seed;
    logic        o_seed_error;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lcg_ledger ledger = new();

    // steady: neither side idles; squeeze: receiver starts a long hold-off
    bit steady  = 1'b0;
    bit squeeze = 1'b0;

    minimal_standard_lcg_range_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_seed_in      (i_seed_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_ranged_value (o_ranged_value),
        .o_raw_seed     (o_raw_seed),
        .o_seed_error   (o_seed_error),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // apb write: setup cycle, then access cycle; taken at the edge closing the access
    task automatic write_range(input logic idx, input logic [31:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ledger.set_bound(idx, v);
    endtask

    // offer one request and hold it until the transfer; valid is left high afterwards
    task automatic offer_request(input logic op, input logic [30:0] sd);
        if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PERCENT);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_seed_in   <= sd;
        do @(posedge i_clk); while (o_in_stall);
        ledger.note_request(op, sd);
    endtask

    // drop valid and wait until every predicted result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (ledger.owed.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_bounds(input logic [31:0] a, input logic [31:0] b);
        drain_results();
        write_range(mslcg_pkg::REG_RANGE_LOW, a);
        write_range(mslcg_pkg::REG_RANGE_HIGH, b);
    endtask

    // mostly draws, with valid loads, rejected loads and tiny or top seeds mixed in
    task automatic random_request();
        int          roll;
        logic        op;
        logic [30:0] sd;
        roll = $urandom_range(99);
        sd   = 31'($urandom);
        if (roll < 75) begin
            op = mslcg_pkg::OP_DRAW;
        end else if (roll < 90) begin
            op = mslcg_pkg::OP_LOAD;
        end else if (roll < 95) begin
            op = mslcg_pkg::OP_LOAD;
            sd = ($urandom_range(1) == 0) ? 31'd0 : mslcg_pkg::SEED_ONES;
        end else begin
            op = mslcg_pkg::OP_LOAD;
            sd = ($urandom_range(1) == 0) ? 31'($urandom_range(5, 1))
                                          : mslcg_pkg::SEED_ONES - 31'd1;
        end
        offer_request(op, sd);
    endtask

    task automatic phase_bounds(input int k, output logic [31:0] a, output logic [31:0] b);
        int base;
        base = int'($urandom_range(200)) - 100;
        unique case (k)
            0: begin a = RANGE_MIN;               b = RANGE_MAX;               end
            1: begin a = RANGE_MAX;               b = RANGE_MIN;               end
            2: begin a = $urandom;                b = a;                       end
            3: begin a = base;                    b = base + $urandom_range(9); end
            4: begin a = $urandom;                b = $urandom;                end
            5: begin a = RANGE_MIN;               b = RANGE_MIN;               end
            6: begin a = RANGE_MAX;               b = RANGE_MAX;               end
            7: begin a = RANGE_MAX;               b = RANGE_MAX - 32'd1;       end
            8: begin a = base + $urandom_range(9); b = base;                   end
            default: begin a = 32'd0;             b = 32'd2;                   end
        endcase
    endtask

    // receiver: checks each transfer and stalls at random, or holds off on request
    initial begin : result_side
        int unsigned hold_left;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                ledger.check_result(o_ranged_value, o_raw_seed, o_seed_error);
            end
            if (squeeze) begin
                squeeze   = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (steady) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    // stimulus
    initial begin : request_side
        logic [31:0] a;
        logic [31:0] b;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_operation <= mslcg_pkg::OP_DRAW;
        i_seed_in   <= 31'd0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= 3'd0;
        pwdata      <= 32'd0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset bounds [0, 2]: reset seed, rejected loads, seed extremes
        offer_request(mslcg_pkg::OP_DRAW, mslcg_pkg::SEED_ONES);
        offer_request(mslcg_pkg::OP_LOAD, 31'd0);
        offer_request(mslcg_pkg::OP_LOAD, mslcg_pkg::SEED_ONES);
        offer_request(mslcg_pkg::OP_DRAW, 31'd0);
        offer_request(mslcg_pkg::OP_LOAD, 31'd1);
        offer_request(mslcg_pkg::OP_DRAW, 31'h2AAA_AAAA);
        offer_request(mslcg_pkg::OP_DRAW, 31'h5555_5555);
        offer_request(mslcg_pkg::OP_LOAD, mslcg_pkg::SEED_ONES - 31'd1);
        offer_request(mslcg_pkg::OP_DRAW, 31'd0);
        offer_request(mslcg_pkg::OP_LOAD, 31'h2AAA_AAAA);
        offer_request(mslcg_pkg::OP_DRAW, 31'd0);
        offer_request(mslcg_pkg::OP_LOAD, 31'h5555_5555);
        offer_request(mslcg_pkg::OP_DRAW, 31'd0);

        // full 32-bit span
        set_bounds(RANGE_MIN, RANGE_MAX);
        offer_request(mslcg_pkg::OP_DRAW, 31'd0);
        offer_request(mslcg_pkg::OP_LOAD, mslcg_pkg::SEED_ONES - 31'd1);
        offer_request(mslcg_pkg::OP_DRAW, 31'd0);

        // full span with the bounds swapped
        set_bounds(RANGE_MAX, RANGE_MIN);
        offer_request(mslcg_pkg::OP_LOAD, 31'd1);
        offer_request(mslcg_pkg::OP_DRAW, 31'd0);
        offer_request(mslcg_pkg::OP_DRAW, 31'd0);

        // small swapped range across zero
        set_bounds(32'd7, -32'sd3);
        offer_request(mslcg_pkg::OP_DRAW, 31'd0);
        offer_request(mslcg_pkg::OP_DRAW, 31'd0);

        for (int k = 0; k < NUM_PHASES; k++) begin
            phase_bounds(k, a, b);
            set_bounds(a, b);
            steady = (k == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // long receiver hold-off while requests keep coming
                if (k == 5 && n == 40) begin
                    squeeze = 1'b1;
                end
                random_request();
            end
            steady = 1'b0;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (ledger.faults == 0 && ledger.owed.size() == 0) begin
            $display("minimal_standard_lcg_range_top regression: pass");
        end else begin
            $display("minimal_standard_lcg_range_top regression: fail");
        end
        $finish;
    end

    // watchdog
    initial begin : run_limit
        #5_000_000;
        $display("minimal_standard_lcg_range_top regression: fail");
        $finish;
    end

endmodule
